[hdl/mass_pkg.sv]
package mass_pkg;

   // Default sizes of the scheduler.
   localparam int AXES_DEFAULT           = 5;
   localparam int POSITION_WIDTH_DEFAULT = 24;
   localparam int TIME_WIDTH_DEFAULT     = 32;

   // Fixed field widths.
   localparam int TARGET_WIDTH    = 24;
   localparam int INTERVAL_WIDTH  = 10;
   localparam int POLARITY_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 10;

   // Motion rules.
   localparam int NEAR_STEP      = 3;
   localparam int REACH_BAND     = 5;
   localparam int BASE_INTERVAL  = 1000;
   localparam int INTERVAL_SLOPE = 50;

   // The remaining distance only matters up to the point where the interval
   // formula drops below zero, so it is carried in a few bits with a cap.
   localparam int REM_WIDTH = 6;
   localparam logic [REM_WIDTH-1:0] REM_CAP = '1;

   localparam logic [INTERVAL_WIDTH-1:0] RESET_MIN_INTERVAL = 10'd400;
   localparam logic [POLARITY_WIDTH-1:0] RESET_POLARITY     = 5'd21;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_INTERVAL       = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DIRECTION_POLARITY = 4'd1;

   // Outcome of one axis visit, handed from the axis pipeline to the sequencer.
   typedef struct packed {
      logic valid;
      logic step;
      logic near;
      logic level;
   } axis_result_type;

endpackage

[hdl/mass_state_mem.sv]
module mass_state_mem #(
   parameter int AXES           = mass_pkg::AXES_DEFAULT,
   parameter int POSITION_WIDTH = mass_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TIME_WIDTH     = mass_pkg::TIME_WIDTH_DEFAULT,
   parameter int AW             = (AXES > 1) ? $clog2(AXES) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    rd_en,
   input  logic [AW-1:0]                           rd_addr,
   output logic                                    rd_valid,
   output logic [AW-1:0]                           rd_axis,
   output logic signed [POSITION_WIDTH-1:0]        rd_pos,
   output logic [TIME_WIDTH-1:0]                   rd_time,
   output logic [mass_pkg::INTERVAL_WIDTH-1:0]     rd_interval,
   output logic                                    rd_pin,
   input  logic                                    wr_en,
   input  logic [AW-1:0]                           wr_addr,
   input  logic signed [POSITION_WIDTH-1:0]        wr_pos,
   input  logic [TIME_WIDTH-1:0]                   wr_time,
   input  logic [mass_pkg::INTERVAL_WIDTH-1:0]     wr_interval,
   input  logic                                    wr_pin
);
   import mass_pkg::*;

   localparam int EW = POSITION_WIDTH + TIME_WIDTH + INTERVAL_WIDTH + 1;

   logic [EW-1:0]   mem [AXES];
   logic [AXES-1:0] written_ff;
   logic [EW-1:0]   entry_ff;
   logic            hit_ff;
   logic            rd_valid_ff;
   logic [AW-1:0]   rd_axis_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_pos, wr_time, wr_interval, wr_pin};
      end
   end

   // One flag per entry; an entry never written reads as its reset state.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_ff   <= mem[rd_addr];
         hit_ff     <= written_ff[rd_addr];
         rd_axis_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_axis  = rd_axis_ff;

   always_comb begin
      if (hit_ff) begin
         {rd_pos, rd_time, rd_interval, rd_pin} = entry_ff;
      end else begin
         rd_pos      = '0;
         rd_time     = '0;
         rd_interval = RESET_MIN_INTERVAL;
         rd_pin      = ~rd_axis_ff[0];
      end
   end

endmodule

[hdl/mass_axis_update.sv]
module mass_axis_update #(
   parameter int POSITION_WIDTH = mass_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TIME_WIDTH     = mass_pkg::TIME_WIDTH_DEFAULT,
   parameter int AW             = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [AW-1:0]                           in_axis,
   input  logic signed [mass_pkg::TARGET_WIDTH-1:0] target,
   input  logic signed [POSITION_WIDTH-1:0]        pos,
   input  logic [TIME_WIDTH-1:0]                   last_time,
   input  logic [mass_pkg::INTERVAL_WIDTH-1:0]     interval,
   input  logic                                    pin,
   input  logic                                    pol,
   input  logic [TIME_WIDTH-1:0]                   now,
   input  logic [mass_pkg::INTERVAL_WIDTH-1:0]     min_interval,
   output mass_pkg::axis_result_type               result,
   output logic [AW-1:0]                           result_axis,
   output logic                                    wr_en,
   output logic signed [POSITION_WIDTH-1:0]        wr_pos,
   output logic [TIME_WIDTH-1:0]                   wr_time,
   output logic [mass_pkg::INTERVAL_WIDTH-1:0]     wr_interval,
   output logic                                    wr_pin
);
   import mass_pkg::*;

   localparam int DW = ((POSITION_WIDTH > TARGET_WIDTH) ? POSITION_WIDTH : TARGET_WIDTH) + 1;
   localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
   localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
   localparam int PW_PROD = REM_WIDTH + 6;
   localparam int PW_IV   = PW_PROD + 1;

   // First stage: distance, elapsed time and the step decision.
   logic signed [DW-1:0]        t_ext;
   logic signed [DW-1:0]        p_ext;
   logic signed [DW-1:0]        diff;
   logic [DW-1:0]               distance;
   logic                        neg;
   logic [TIME_WIDTH-1:0]       elapsed;
   logic                        step;
   logic                        near_band;
   logic                        wrap;
   logic [REM_WIDTH-1:0]        dsat;

   always_comb begin
      t_ext     = DW'(target);
      p_ext     = DW'(pos);
      diff      = t_ext - p_ext;
      neg       = diff[DW-1];
      distance  = neg ? DW'(-diff) : DW'(diff);
      elapsed   = now - last_time;
      step      = (distance > DW'(NEAR_STEP)) && (elapsed > TIME_WIDTH'(interval));
      near_band = distance <= DW'(REACH_BAND);
      wrap      = neg ? (pos == POS_MIN) : (pos == POS_MAX);
      dsat      = (distance > DW'(REM_CAP)) ? REM_CAP : distance[REM_WIDTH-1:0];
   end

   logic                              s1_valid_ff;
   logic [AW-1:0]                     s1_axis_ff;
   logic                              s1_step_ff;
   logic                              s1_near_ff;
   logic                              s1_neg_ff;
   logic                              s1_wrap_ff;
   logic [REM_WIDTH-1:0]              s1_dsat_ff;
   logic signed [POSITION_WIDTH-1:0]  s1_pos_ff;
   logic                              s1_pin_ff;
   logic                              s1_pol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_axis_ff <= in_axis;
      s1_step_ff <= step;
      s1_near_ff <= !step && near_band;
      s1_neg_ff  <= neg;
      s1_wrap_ff <= wrap;
      s1_dsat_ff <= dsat;
      s1_pos_ff  <= pos;
      s1_pin_ff  <= pin;
      s1_pol_ff  <= pol;
   end

   // Second stage: new position, direction and interval. After a step the
   // remaining distance is one less, unless the position wrapped, in which
   // case it is far beyond the point where the floor takes over.
   logic [REM_WIDTH-1:0]      rem;
   logic [PW_PROD-1:0]        slope_prod;
   logic signed [PW_IV-1:0]   iv_raw;
   logic                      new_pin;

   always_comb begin
      rem        = s1_wrap_ff ? REM_CAP : (s1_dsat_ff - REM_WIDTH'(1));
      slope_prod = PW_PROD'(INTERVAL_SLOPE) * PW_PROD'(rem);
      iv_raw     = $signed(PW_IV'(BASE_INTERVAL)) - $signed({1'b0, slope_prod});
      new_pin    = s1_neg_ff ? ~s1_pol_ff : s1_pol_ff;
      wr_pos     = s1_neg_ff ? (s1_pos_ff - POSITION_WIDTH'(1))
                             : (s1_pos_ff + POSITION_WIDTH'(1));
      if (iv_raw < $signed({{(PW_IV-INTERVAL_WIDTH){1'b0}}, min_interval})) begin
         wr_interval = min_interval;
      end else begin
         wr_interval = iv_raw[INTERVAL_WIDTH-1:0];
      end
   end

   assign wr_en        = s1_valid_ff && s1_step_ff;
   assign wr_time      = now;
   assign wr_pin       = new_pin;
   assign result_axis  = s1_axis_ff;
   assign result.valid = s1_valid_ff;
   assign result.step  = s1_step_ff;
   assign result.near  = s1_near_ff;
   assign result.level = s1_step_ff ? new_pin : s1_pin_ff;

endmodule

[hdl/multi_axis_step_scheduler.sv]
// Channel   Ports                      Beat contents (lowest bits first)
// req       req_tvalid/tready/tdata    current_time, target_axis_0 .. target_axis_N-1
// rsp       rsp_tvalid/tready/tdata    step_mask, direction_levels
//           rsp_tuser                  target_reached
// csr       csr_valid/ready/index/data register index and write data
//
// The block takes no new tick until the current one is handed over. The
// per-axis state memory is read one axis per cycle, the last axis then
// passes the memory read register and the update stage register, and the
// DONE state hands the result over once the output register is free.
// Reset is synchronous and active high; the state memory needs no clearing
// pass because each entry carries a written flag that reset clears at once.
// A finished result waits in the output register; the next tick is already
// taken while it waits, and only its own result holds off until the slot frees.
module multi_axis_step_scheduler #(
   parameter int AXES           = mass_pkg::AXES_DEFAULT,
   parameter int POSITION_WIDTH = mass_pkg::POSITION_WIDTH_DEFAULT,
   parameter int TIME_WIDTH     = mass_pkg::TIME_WIDTH_DEFAULT,
   parameter int REQ_DATA_WIDTH =
      ((TIME_WIDTH + AXES * mass_pkg::TARGET_WIDTH + 7) / 8) * 8,
   parameter int RSP_DATA_WIDTH = ((2 * AXES + 7) / 8) * 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // current_time, then target_axis_0 .. target_axis_(AXES-1), zero padded
   input  logic [REQ_DATA_WIDTH-1:0]               req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // step_mask, then direction_levels, zero padded
   output logic [RSP_DATA_WIDTH-1:0]               rsp_tdata,
   // target_reached
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mass_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mass_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import mass_pkg::*;

   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int CW = $clog2(AXES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Configuration registers. Writes are always taken; unknown indexes drop.
   logic [INTERVAL_WIDTH-1:0] min_interval_ff;
   logic [POLARITY_WIDTH-1:0] polarity_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= RESET_MIN_INTERVAL;
         polarity_ff     <= RESET_POLARITY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_INTERVAL: begin
               min_interval_ff <= csr_data[INTERVAL_WIDTH-1:0];
            end
            CSR_DIRECTION_POLARITY: begin
               polarity_ff <= csr_data[POLARITY_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Polarity bits repeat every five axes when more axes are built.
   logic [AXES-1:0] pol_vec;
   for (genvar g = 0; g < AXES; g++) begin : g_pol
      assign pol_vec[g] = polarity_ff[g % POLARITY_WIDTH];
   end

   // Sequencer: IDLE takes a tick, RUN walks the axes through the memory,
   // DONE hands the collected result to the output register.
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          req_take;
   logic          rd_en;
   logic          rsp_load;

   logic [TIME_WIDTH-1:0]          now_ff;
   logic signed [TARGET_WIDTH-1:0] targets_ff [AXES];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rd_en      = (state_ff == ST_RUN) && (rd_cnt_ff < CW'(AXES));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_tvalid || rsp_tready);

   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff <= req_tdata[TIME_WIDTH-1:0];
         for (int i = 0; i < AXES; i++) begin
            targets_ff[i] <= req_tdata[TIME_WIDTH + i * TARGET_WIDTH +: TARGET_WIDTH];
         end
      end
   end

   // Memory read side.
   logic                              mem_valid;
   logic [AW-1:0]                     mem_axis;
   logic signed [POSITION_WIDTH-1:0]  mem_pos;
   logic [TIME_WIDTH-1:0]             mem_time;
   logic [INTERVAL_WIDTH-1:0]         mem_interval;
   logic                              mem_pin;

   // Write-back side from the axis pipeline.
   axis_result_type                   res;
   logic [AW-1:0]                     res_axis;
   logic                              wr_en;
   logic signed [POSITION_WIDTH-1:0]  wr_pos;
   logic [TIME_WIDTH-1:0]             wr_time;
   logic [INTERVAL_WIDTH-1:0]         wr_interval;
   logic                              wr_pin;

   mass_state_mem #(
      .AXES           (AXES),
      .POSITION_WIDTH (POSITION_WIDTH),
      .TIME_WIDTH     (TIME_WIDTH),
      .AW             (AW)
   ) u_state_mem (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_addr     (rd_cnt_ff[AW-1:0]),
      .rd_valid    (mem_valid),
      .rd_axis     (mem_axis),
      .rd_pos      (mem_pos),
      .rd_time     (mem_time),
      .rd_interval (mem_interval),
      .rd_pin      (mem_pin),
      .wr_en       (wr_en),
      .wr_addr     (res_axis),
      .wr_pos      (wr_pos),
      .wr_time     (wr_time),
      .wr_interval (wr_interval),
      .wr_pin      (wr_pin)
   );

   // Each axis is a separate entry and one tick finishes all its writes
   // before the next tick reads, so no forwarding path is needed.
   mass_axis_update #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .TIME_WIDTH     (TIME_WIDTH),
      .AW             (AW)
   ) u_axis_update (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mem_valid),
      .in_axis      (mem_axis),
      .target       (targets_ff[mem_axis]),
      .pos          (mem_pos),
      .last_time    (mem_time),
      .interval     (mem_interval),
      .pin          (mem_pin),
      .pol          (pol_vec[mem_axis]),
      .now          (now_ff),
      .min_interval (min_interval_ff),
      .result       (res),
      .result_axis  (res_axis),
      .wr_en        (wr_en),
      .wr_pos       (wr_pos),
      .wr_time      (wr_time),
      .wr_interval  (wr_interval),
      .wr_pin       (wr_pin)
   );

   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in  = ST_RUN;
               rd_cnt_in = '0;
            end
         end
         ST_RUN: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + CW'(1);
            end
            // Axes come back in order, so the last one closes the tick.
            if (res.valid && (res_axis == AW'(AXES - 1))) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   // Collect the per-axis outcomes of the tick.
   logic [AXES-1:0] mask_ff;
   logic [AXES-1:0] levels_ff;
   logic            near_all_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         mask_ff     <= '0;
         levels_ff   <= '0;
         near_all_ff <= 1'b1;
      end else if (res.valid) begin
         mask_ff[res_axis]   <= res.step;
         levels_ff[res_axis] <= res.level;
         near_all_ff         <= near_all_ff && res.near;
      end
   end

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [AXES-1:0]           rsp_mask_ff;
   logic [AXES-1:0]           rsp_levels_ff;
   logic                      rsp_reached_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mask_ff    <= mask_ff;
         rsp_levels_ff  <= levels_ff;
         rsp_reached_ff <= near_all_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_levels_ff, rsp_mask_ff});
   assign rsp_tuser  = rsp_reached_ff;

endmodule

[dv/tb_multi_axis_step_scheduler.sv]
module tb_multi_axis_step_scheduler;
   import mass_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXES_N   = AXES_DEFAULT;
   localparam int POS_W    = POSITION_WIDTH_DEFAULT;
   localparam int TIME_W   = TIME_WIDTH_DEFAULT;
   localparam int REQ_W    = ((TIME_W + AXES_N * TARGET_WIDTH + 7) / 8) * 8;
   localparam int RSP_W    = ((2 * AXES_N + 7) / 8) * 8;

   localparam int PHASES        = 5;
   localparam int PHASE_TICKS   = 258;
   localparam int RESET_CYCLES  = 12;
   localparam int DRAIN_CYCLES  = 32;
   localparam int MAX_WAIT      = 13;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // The first register index past the defined ones; everything from here up
   // to the top of the index range is unmapped and must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNMAPPED = CSR_DIRECTION_POLARITY + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_UNMAPPED  = '1;

   // One tick as it travels on the request channel.
   typedef struct packed {
      logic [TIME_W-1:0]                          now;
      logic [AXES_N-1:0][TARGET_WIDTH-1:0]        target;
   } tick_type;

   // One result beat: step pulses, held direction levels and the reached flag.
   typedef struct packed {
      logic [AXES_N-1:0] step_mask;
      logic [AXES_N-1:0] levels;
      logic              reached;
   } step_report_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   // A row of the directed table. Ticks whose outcome is obvious carry the
   // expected beat typed in; all others are left to the scheduler model.
   typedef struct {
      row_kind_type               kind;
      tick_type                   tick;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
      bit                         typed;
      step_report_type            want;
   } plan_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic [REQ_W-1:0]            req_tdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [RSP_W-1:0]            rsp_tdata;
   logic                        rsp_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data = '0;

   // Shadow of the block's per-axis state and of its two registers.
   logic signed [POS_W-1:0]     axis_pos  [AXES_N];
   logic [TIME_W-1:0]           last_step [AXES_N];
   logic [INTERVAL_WIDTH-1:0]   step_gap  [AXES_N];
   logic                        dir_pin   [AXES_N];
   logic [INTERVAL_WIDTH-1:0]   floor_us;
   logic [POLARITY_WIDTH-1:0]   polarity;

   step_report_type             pending_reports[$];
   plan_row_type                plan[$];

   int                          ticks_sent = 0;
   int                          results_seen = 0;
   int                          fail_count = 0;
   int                          settings_used = 0;
   int                          steps_total = 0;
   int                          reached_total = 0;
   int unsigned                 cycle_count = 0;
   logic [TIME_W-1:0]           clock_us = '0;
   bit                          req_calm = 1'b0;

   multi_axis_step_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scheduler model: visits the axes in order and decides for each one
   // whether it steps, updating the shadow state exactly as the block should.
   function automatic step_report_type schedule_tick(input tick_type t);
      step_report_type   r;
      longint            aim_l;
      longint            diff;
      longint            distance;
      longint            rem;
      longint            iv;
      logic [TIME_W-1:0] elapsed;
      logic              pol;
      int                near_axes;
      r = '0;
      near_axes = 0;
      for (int a = 0; a < AXES_N; a++) begin
         aim_l = longint'($signed(t.target[a]));
         diff = aim_l - longint'(axis_pos[a]);
         distance = (diff < 0) ? -diff : diff;
         // Elapsed time wraps with the free-running microsecond counter.
         elapsed = t.now - last_step[a];
         if (distance > NEAR_STEP && elapsed > step_gap[a]) begin
            pol = polarity[a];
            // Moving toward a lower position drives the inverse of the polarity.
            dir_pin[a] = (diff > 0) ? pol : !pol;
            if (diff > 0) begin
               axis_pos[a] = axis_pos[a] + 24'sd1;
            end else begin
               axis_pos[a] = axis_pos[a] - 24'sd1;
            end
            rem = aim_l - longint'(axis_pos[a]);
            if (rem < 0) begin
               rem = -rem;
            end
            last_step[a] = t.now;
            // Far from the target the formula falls below the floor, or even
            // below zero, and the floor takes over.
            iv = BASE_INTERVAL - INTERVAL_SLOPE * rem;
            if (iv < longint'(floor_us)) begin
               iv = longint'(floor_us);
            end
            step_gap[a] = INTERVAL_WIDTH'(iv);
            r.step_mask[a] = 1'b1;
            steps_total++;
         end else if (distance <= REACH_BAND) begin
            near_axes++;
         end
         r.levels[a] = dir_pin[a];
      end
      r.reached = (near_axes == AXES_N);
      if (r.reached) begin
         reached_total++;
      end
      return r;
   endfunction

   // Each side draws a wait before every beat; a calm stretch forces zero so
   // that back-to-back traffic is exercised as well.
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic add_tick(input logic [TIME_W-1:0] now,
                           input logic [AXES_N-1:0][TARGET_WIDTH-1:0] target,
                           input bit typed = 1'b0,
                           input logic [AXES_N-1:0] mask = '0,
                           input logic [AXES_N-1:0] levels = '0,
                           input logic reached = 1'b0);
      plan_row_type row;
      row.kind = ROW_TICK;
      row.tick.now = now;
      row.tick.target = target;
      row.index = '0;
      row.value = '0;
      row.typed = typed;
      row.want.step_mask = mask;
      row.want.levels = levels;
      row.want.reached = reached;
      plan.push_back(row);
   endtask

   task automatic add_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      plan_row_type row;
      row.kind = ROW_WRITE;
      row.tick = '0;
      row.index = index;
      row.value = value;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endtask

   // Sends one tick beat. Valid is only lowered when a gap is drawn, so a
   // zero gap keeps it high across consecutive beats. The model runs at the
   // accepting edge, and the expected beat is queued there.
   task automatic drive_tick(input tick_type t, input bit typed,
                             input step_report_type want);
      step_report_type predicted;
      int              gap;
      if ($urandom_range(0, 39) == 0) begin
         req_calm = !req_calm;
      end
      gap = draw_gap(req_calm);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({t.target, t.now});
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      clock_us = t.now;
      predicted = schedule_tick(t);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   // Register writes only go out once every tick has produced its beat.
   // Valid is left high after the accepting edge; the next tick or write
   // takes it over in a single assignment.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      req_tvalid <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MIN_INTERVAL: begin
            floor_us = value[INTERVAL_WIDTH-1:0];
            settings_used++;
         end
         CSR_DIRECTION_POLARITY: begin
            polarity = value[POLARITY_WIDTH-1:0];
            settings_used++;
         end
         default: begin
         end
      endcase
   endtask

   // Result side: random stalls on tready, same wait range as the sender.
   initial begin : rsp_side
      int stall;
      bit calm;
      calm = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            calm = !calm;
         end
         stall = draw_gap(calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Every accepted result beat is held against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      step_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_reports.size() == 0) begin
            $error("result beat with no tick outstanding: tdata %0h tuser %0b",
                   rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[AXES_N-1:0] !== want.step_mask) begin
               $error("step_mask expected %0h actual %0h",
                      want.step_mask, rsp_tdata[AXES_N-1:0]);
               fail_count++;
            end
            if (rsp_tdata[2*AXES_N-1:AXES_N] !== want.levels) begin
               $error("direction_levels expected %0h actual %0h",
                      want.levels, rsp_tdata[2*AXES_N-1:AXES_N]);
               fail_count++;
            end
            if (rsp_tuser !== want.reached) begin
               $error("target_reached expected %0b actual %0b", want.reached, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run, far above the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_multi_axis_step_scheduler: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      tick_type                      t;
      step_report_type               none;
      logic [INTERVAL_WIDTH-1:0]     floor_pick;
      logic [POLARITY_WIDTH-1:0]     pol_pick;
      int                            directed_ticks;
      int                            pick;
      int                            offset;

      // Shadow state as reset leaves it: positions at zero rather than a
      // kinematic home, even axes with their direction pin high.
      floor_us = RESET_MIN_INTERVAL;
      polarity = RESET_POLARITY;
      for (int a = 0; a < AXES_N; a++) begin
         axis_pos[a]  = '0;
         last_step[a] = '0;
         step_gap[a]  = RESET_MIN_INTERVAL;
         dir_pin[a]   = (a % 2 == 0);
      end
      none = '0;
      directed_ticks = 0;

      // Directed table. With the reset floor of 400 and polarity 10101 the
      // first rows can be worked out by hand.
      add_tick(32'd0, {AXES_N{24'h000000}}, 1'b1, 5'h00, 5'h15, 1'b1);
      add_tick(32'd401, {AXES_N{24'h000004}}, 1'b1, 5'h1F, 5'h15, 1'b0);
      // Most negative target while the 850 us interval still holds.
      add_tick(32'd402, {AXES_N{24'h800000}}, 1'b1, 5'h00, 5'h15, 1'b0);
      // Negative motion flips every pin; the far target pins the interval
      // at the floor.
      add_tick(32'd1252, {AXES_N{24'h800000}}, 1'b1, 5'h1F, 5'h0A, 1'b0);
      add_tick(32'd1652, {AXES_N{24'h7FFFFF}}, 1'b1, 5'h00, 5'h0A, 1'b0);
      add_tick(32'd1653, {AXES_N{24'h7FFFFF}}, 1'b1, 5'h1F, 5'h15, 1'b0);
      // Reached band: one axis six away spoils it, five away in either sense
      // still counts.
      add_tick(32'd2000, {24'd1, 24'd1, 24'd1, 24'd7, 24'd6}, 1'b1, 5'h00, 5'h15, 1'b0);
      add_tick(32'd2001, {24'd1, 24'd1, 24'd1, 24'hFFFFFC, 24'd6}, 1'b1, 5'h00, 5'h15,
               1'b1);
      // A stepping axis never counts toward reached, even close by.
      add_tick(32'd2100, {24'd1, 24'd1, 24'd1, 24'd1, 24'd5}, 1'b1, 5'h01, 5'h15, 1'b0);
      add_write(CSR_MIN_INTERVAL, 10'd0);
      add_write(CSR_DIRECTION_POLARITY, 10'h3EA);
      add_write(CSR_LAST_UNMAPPED, 10'h3FF);
      // Time wraps from the top of the counter back through zero.
      add_tick(32'hFFFF_FFFF, {AXES_N{24'hFFFF9C}});
      add_tick(32'h0000_0004, {AXES_N{24'hFFFF9C}});
      add_write(CSR_MIN_INTERVAL, 10'd1023);
      add_tick(32'd10, {AXES_N{24'd100}});
      add_tick(32'd1033, {AXES_N{24'd100}});
      add_tick(32'd1034, {AXES_N{24'd100}});
      add_write(CSR_DIRECTION_POLARITY, 10'h01F);
      add_tick(32'd2100, {AXES_N{24'hFFFF9C}});
      add_tick(32'd2101, {24'd3, 24'hFFFFFB, 24'd0, 24'd5, 24'hFFFFFD});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            write_reg(plan[i].index, plan[i].value);
         end else begin
            drive_tick(plan[i].tick, plan[i].typed, plan[i].want);
            directed_ticks++;
         end
      end

      // Random phases, each under its own register setting. Most targets sit
      // a few steps from the current position so that axes settle, reach the
      // band and pick up the distance-dependent intervals.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               floor_pick = 10'd1000;
               pol_pick   = 5'h00;
            end
            1: begin
               floor_pick = 10'd0;
               pol_pick   = 5'h1F;
            end
            2: begin
               floor_pick = 10'd1023;
               pol_pick   = POLARITY_WIDTH'($urandom);
            end
            3: begin
               floor_pick = INTERVAL_WIDTH'($urandom_range(0, 1023));
               pol_pick   = POLARITY_WIDTH'($urandom);
               // Run this phase up to and across the wrap of the time counter.
               clock_us   = 32'hFFFF_F000;
            end
            default: begin
               floor_pick = RESET_MIN_INTERVAL;
               pol_pick   = RESET_POLARITY;
            end
         endcase
         write_reg(CSR_MIN_INTERVAL, floor_pick);
         write_reg(CSR_DIRECTION_POLARITY,
                   {CSR_DATA_WIDTH'($urandom) >> POLARITY_WIDTH << POLARITY_WIDTH} |
                   CSR_DATA_WIDTH'(pol_pick));
         write_reg(CSR_INDEX_WIDTH'($urandom_range(int'(CSR_FIRST_UNMAPPED),
                                                   int'(CSR_LAST_UNMAPPED))),
                   CSR_DATA_WIDTH'($urandom));
         t.target = '0;
         for (int a = 0; a < AXES_N; a++) begin
            t.target[a] = axis_pos[a];
         end
         for (int n = 0; n < PHASE_TICKS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               t.now = clock_us + TIME_W'($urandom_range(0, 1100));
            end else if (pick < 90) begin
               t.now = clock_us + TIME_W'($urandom_range(0, 60));
            end else if (pick < 96) begin
               t.now = clock_us + TIME_W'($urandom);
            end else begin
               t.now = TIME_W'($urandom);
            end
            for (int a = 0; a < AXES_N; a++) begin
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  offset = $urandom_range(0, 20) - 10;
                  t.target[a] = TARGET_WIDTH'(int'(axis_pos[a]) + offset);
               end else if (pick < 80) begin
                  // Keep chasing the previous target.
               end else if (pick < 92) begin
                  offset = $urandom_range(0, 400) - 200;
                  t.target[a] = TARGET_WIDTH'(int'(axis_pos[a]) + offset);
               end else begin
                  t.target[a] = TARGET_WIDTH'($urandom);
               end
            end
            drive_tick(t, 1'b0, none);
         end
      end

      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (results_seen != ticks_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_reports.size());
         fail_count += pending_reports.size();
      end

      $display("Ran %0d ticks (%0d from the directed table) over %0d register writes.",
               ticks_sent, directed_ticks, settings_used);
      $display("Model saw %0d axis steps and %0d ticks with every axis in the reached band.",
               steps_total, reached_total);
      if (fail_count == 0) begin
         $display("tb_multi_axis_step_scheduler: PASS");
      end else begin
         $display("tb_multi_axis_step_scheduler: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/mass_pkg.sv
hdl/mass_state_mem.sv
hdl/mass_axis_update.sv
hdl/multi_axis_step_scheduler.sv
dv/tb_multi_axis_step_scheduler.sv
